>>> rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define KST_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> rtl/core/kst_pkg.sv
// shared types and codes of the keyed slot table
`default_nettype none

package kst_pkg;

	localparam logic [1:0] MODE_ALLOC = 2'd0;
	localparam logic [1:0] MODE_GET   = 2'd1;
	localparam logic [1:0] MODE_SET   = 2'd2;
	localparam logic [1:0] MODE_FREE  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PRESENT = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	localparam int KEY_W  = 32;
	localparam int WORD_W = 48;
	localparam int SIDX_W = 4;

	typedef struct packed {
		logic [1:0]        mode;
		logic [KEY_W-1:0]  owner_key;
		logic [WORD_W-1:0] write_word;
	} kst_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [WORD_W-1:0] read_word;
		logic [SIDX_W-1:0] slot_index;
	} kst_rsp_t;

	// slot updates applied at the end of a search pass
	typedef enum logic [1:0] {
		UPD_ALLOC,
		UPD_SET,
		UPD_FREE
	} kst_upd_t;

	typedef struct packed {
		logic              en;
		kst_upd_t          op;
		logic [KEY_W-1:0]  key;
		logic [WORD_W-1:0] word;
	} kst_cmd_t;

	// search token handed from cell to cell
	typedef struct packed {
		logic              vld;
		logic              hit;
		logic              free;
		logic [WORD_W-1:0] word;
	} kst_tok_t;

endpackage

`default_nettype wire

>>> rtl/core/kst_cell.sv
// one slot of the table: holds valid, key and word, passes the search token on
`default_nettype none

module kst_cell #(
	parameter int IW  = 4,
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [kst_pkg::KEY_W-1:0]     req_key,
	input  kst_pkg::kst_tok_t             tok_in,
	input  logic [IW-1:0]                 hit_idx_in,
	input  logic [IW-1:0]                 free_idx_in,
	output kst_pkg::kst_tok_t             tok_out,
	output logic [IW-1:0]                 hit_idx_out,
	output logic [IW-1:0]                 free_idx_out,
	input  kst_pkg::kst_cmd_t             cmd,
	input  logic [IW-1:0]                 cmd_idx
);
	import kst_pkg::*;

	logic              valid_q;
	logic [KEY_W-1:0]  key_q;
	logic [WORD_W-1:0] word_q;
	logic              tok_vld_q;
	kst_tok_t          tok_d;
	kst_tok_t          tok_q;
	logic [IW-1:0]     hit_idx_d, free_idx_d, hit_idx_q, free_idx_q;
	logic              match, take_hit, take_free, sel;

	assign match     = valid_q && (key_q == req_key);
	assign take_hit  = tok_in.vld && !tok_in.hit && match;
	assign take_free = tok_in.vld && !tok_in.free && !valid_q;
	assign sel       = cmd.en && (cmd_idx == IW'(IDX));

	always_comb begin
		tok_d      = tok_in;
		hit_idx_d  = hit_idx_in;
		free_idx_d = free_idx_in;
		if (take_hit) begin
			tok_d.hit  = 1'b1;
			tok_d.word = word_q;
			hit_idx_d  = IW'(IDX);
		end
		if (take_free) begin
			tok_d.free = 1'b1;
			free_idx_d = IW'(IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			tok_vld_q <= 1'b0;
		end else begin
			tok_vld_q <= tok_in.vld;
			if (sel) begin
				unique case (cmd.op)
					UPD_ALLOC: valid_q <= 1'b1;
					UPD_FREE:  valid_q <= 1'b0;
					default:   valid_q <= valid_q;
				endcase
			end
		end
	end

	// slot payload and token payload
	always_ff @(posedge clk) begin
		tok_q      <= tok_d;
		hit_idx_q  <= hit_idx_d;
		free_idx_q <= free_idx_d;
		if (sel) begin
			unique case (cmd.op)
				UPD_ALLOC: begin
					key_q  <= cmd.key;
					word_q <= '0;
				end
				UPD_SET:  word_q <= cmd.word;
				UPD_FREE: word_q <= '0;
				default:  word_q <= word_q;
			endcase
		end
	end

	always_comb begin
		tok_out     = tok_q;
		tok_out.vld = tok_vld_q;
	end
	assign hit_idx_out  = hit_idx_q;
	assign free_idx_out = free_idx_q;

endmodule

`default_nettype wire

>>> rtl/core/keyed_slot_table_top.sv
// keyed slot table: a chain of slot cells searched by a travelling token
// done trails the transfer via launch_q, each cell's token reg and done_q
// one request per search pass; the token walks one cell a cycle
// reset: arst_n clears every slot's valid mark and the control state at once
// the result is shown for one cycle on done; the receiver cannot stall
`default_nettype none

module keyed_slot_table_top #(
	parameter int SLOTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kst_pkg::kst_req_t req,
	output logic              done,
	output kst_pkg::kst_rsp_t rsp
);
	import kst_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// request held for the whole search pass
	kst_req_t req_q;
	logic     busy_q;
	logic     launch_q;
	logic     done_q;
	kst_rsp_t rsp_q;

	// token chain: entry 0 is the launch, entry k+1 leaves cell k
	kst_tok_t      tok      [SLOTS+1];
	logic [IW-1:0] hit_idx  [SLOTS+1];
	logic [IW-1:0] free_idx [SLOTS+1];

	kst_cmd_t      cmd;
	logic [IW-1:0] cmd_idx;
	kst_rsp_t      rsp_d;
	logic          fin;
	logic          accept;
	kst_tok_t      last;
	logic [IW+3:0] hit_ext, free_ext;

	assign accept = start && !busy_q;

	// empty token enters the first cell the cycle after the transfer
	always_comb begin
		tok[0]      = '0;
		tok[0].vld  = launch_q;
		hit_idx[0]  = '0;
		free_idx[0] = '0;
	end

	for (genvar k = 0; k < SLOTS; k++) begin : g_cell
		kst_cell #(
			.IW  (IW),
			.IDX (k)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.req_key      (req_q.owner_key),
			.tok_in       (tok[k]),
			.hit_idx_in   (hit_idx[k]),
			.free_idx_in  (free_idx[k]),
			.tok_out      (tok[k+1]),
			.hit_idx_out  (hit_idx[k+1]),
			.free_idx_out (free_idx[k+1]),
			.cmd          (cmd),
			.cmd_idx      (cmd_idx)
		);
	end

	assign last     = tok[SLOTS];
	assign fin      = last.vld;
	// slot number narrowed or widened to the 4-bit result field
	assign hit_ext  = {4'b0, hit_idx[SLOTS]};
	assign free_ext = {4'b0, free_idx[SLOTS]};

	// decide the outcome and the slot update once the token leaves the last cell
	always_comb begin
		rsp_d       = '0;
		cmd         = '0;
		cmd.op      = UPD_SET;
		cmd.key     = req_q.owner_key;
		cmd.word    = req_q.write_word;
		cmd_idx     = hit_idx[SLOTS];
		priority if (req_q.mode == MODE_ALLOC) begin
			priority if (last.hit) begin
				rsp_d.status     = ST_PRESENT;
				rsp_d.slot_index = hit_ext[3:0];
			end else if (last.free) begin
				rsp_d.status     = ST_OK;
				rsp_d.slot_index = free_ext[3:0];
				cmd.en           = fin;
				cmd.op           = UPD_ALLOC;
				cmd_idx          = free_idx[SLOTS];
			end else begin
				rsp_d.status = ST_FULL;
			end
		end else if (!last.hit) begin
			rsp_d.status = ST_MISSING;
		end else begin
			rsp_d.status     = ST_OK;
			rsp_d.slot_index = hit_ext[3:0];
			unique case (req_q.mode)
				MODE_GET: rsp_d.read_word = last.word;
				MODE_SET: begin
					cmd.en = fin;
					cmd.op = UPD_SET;
				end
				MODE_FREE: begin
					cmd.en = fin;
					cmd.op = UPD_FREE;
				end
				default: rsp_d.read_word = '0;
			endcase
		end
	end

	// control: busy from transfer until the pass ends, done for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			launch_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			launch_q <= accept;
			done_q   <= fin;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

>>> rtl/core/kst_checker.sv
// port-level checks of the keyed slot table, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module kst_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input kst_pkg::kst_rsp_t rsp
);
	import kst_pkg::*;

	logic fail_st;

	// result that failed: table full or key not found
	assign fail_st = done && (rsp.status == ST_FULL || rsp.status == ST_MISSING);

	`KST_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`KST_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy)
	`KST_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`KST_ASSERT_SAME(a_fail_idx, clk, arst_n, fail_st, rsp.slot_index == '0)
	`KST_ASSERT_SAME(a_word_ok, clk, arst_n, done && (rsp.status != ST_OK), rsp.read_word == '0)

endmodule

bind keyed_slot_table_top kst_checker u_kst_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire

>>> tb/keyed_slot_table_top_tb.sv
// self-checking testbench of the keyed slot table: directed and random requests
`timescale 1ns / 1ps

module keyed_slot_table_top_tb;

	import kst_pkg::*;

	localparam int SLOTS       = 16;
	// wait margin for stray strobes at the end of the run
	localparam int LATENCY     = SLOTS + 1;
	localparam int CYCLE_LIMIT = 400000;
	// no idling once the queue of pending requests is this short
	localparam int CALM_TAIL   = 100;

	typedef struct {
		kst_req_t req;
		bit       drain;	// hold off until every outstanding result is back
	} pending_req_t;

	logic     clk    = 1'b0;
	logic     arst_n = 1'b0;
	logic     start  = 1'b0;
	kst_req_t req    = '0;
	logic     busy;
	logic     done;
	kst_rsp_t rsp;

	keyed_slot_table_top #(
		.SLOTS(SLOTS)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	always #5 clk = ~clk;

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	// ---------------------------------------------------------------
	// slot model: valid mark, owner key and data word per slot
	// ---------------------------------------------------------------
	logic              tbl_valid [SLOTS];
	logic [KEY_W-1:0]  tbl_key   [SLOTS];
	logic [WORD_W-1:0] tbl_word  [SLOTS];

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i]   = '0;
			tbl_word[i]  = '0;
		end
	end

	// applies one request to the slot model and returns the response it should give
	function automatic kst_rsp_t table_apply(kst_req_t r);
		kst_rsp_t o;
		int       hit;
		int       spare;
		o     = '0;
		hit   = -1;
		spare = -1;
		// lowest matching valid slot, lowest free slot
		for (int i = 0; i < SLOTS; i++) begin
			if (hit < 0 && tbl_valid[i] && tbl_key[i] == r.owner_key)
				hit = i;
			if (spare < 0 && !tbl_valid[i])
				spare = i;
		end
		o.status = ST_OK;
		if (r.mode == MODE_ALLOC) begin
			if (hit >= 0) begin
				o.status     = ST_PRESENT;
				o.slot_index = SIDX_W'(hit);
			end else if (spare < 0) begin
				o.status = ST_FULL;
			end else begin
				// claimed word is already zero from reset or free
				tbl_valid[spare] = 1'b1;
				tbl_key[spare]   = r.owner_key;
				o.slot_index     = SIDX_W'(spare);
			end
		end else if (hit < 0) begin
			o.status = ST_MISSING;
		end else begin
			o.slot_index = SIDX_W'(hit);
			case (r.mode)
				MODE_GET: begin
					o.read_word = tbl_word[hit];
				end
				MODE_SET: begin
					tbl_word[hit] = r.write_word;
				end
				default: begin
					// free keeps the key but drops the mark and the word
					tbl_valid[hit] = 1'b0;
					tbl_word[hit]  = '0;
				end
			endcase
		end
		return o;
	endfunction

	// ---------------------------------------------------------------
	// queues and counters
	// ---------------------------------------------------------------
	pending_req_t pending_reqs [$];
	kst_rsp_t     expected_rsps [$];

	int cycle_count    = 0;
	int mismatch_count = 0;
	int results_seen   = 0;
	int mode_seen   [4] = '{0, 0, 0, 0};
	int status_seen [4] = '{0, 0, 0, 0};

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	// ---------------------------------------------------------------
	// driver: one transfer per start && !busy edge, random idle bursts
	// ---------------------------------------------------------------
	int gap_left  = 0;
	bit gap_on_idle = 1'b0;	// burst counts only cycles where the block is idle

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start    <= 1'b0;
			req      <= '0;
			gap_left <= 0;
		end else begin : drive
			bit           taken;
			bit           calm;
			pending_req_t nxt;
			kst_rsp_t     want;
			taken = start && !busy;
			calm  = pending_reqs.size() < CALM_TAIL;
			if (taken) begin
				want = table_apply(req);
				expected_rsps.push_back(want);
				mode_seen[req.mode]++;
				status_seen[want.status]++;
			end
			if (start && !taken) begin
				// block still busy: keep the request on the port
			end else if (taken && !calm && $urandom_range(0, 2) == 0) begin
				// idle burst, counted down during the search or only after it
				start       <= 1'b0;
				gap_left    <= $urandom_range(0, 16);
				gap_on_idle <= 1'($urandom_range(0, 1));
			end else if (gap_left != 0) begin
				start <= 1'b0;
				if (!gap_on_idle || !busy)
					gap_left <= gap_left - 1;
			end else if (pending_reqs.size() == 0 ||
					(pending_reqs[0].drain && (taken || expected_rsps.size() != 0))) begin
				start <= 1'b0;
			end else begin
				nxt = pending_reqs.pop_front();
				req   <= nxt.req;
				start <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: every strobe is matched against the oldest expectation
	// ---------------------------------------------------------------
	task automatic flag_field(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("mismatch on result %0d, %s: expected %h, got %h",
					results_seen, what, want, got);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin : check
			kst_rsp_t want;
			if (expected_rsps.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result with no request outstanding: status %h word %h slot %h",
						rsp.status, rsp.read_word, rsp.slot_index);
			end else begin
				want = expected_rsps.pop_front();
				flag_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
				flag_field("read_word", want.read_word, rsp.read_word);
				flag_field("slot_index", WORD_W'(want.slot_index),
					WORD_W'(rsp.slot_index));
			end
			results_seen++;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	task automatic push_req(logic [1:0] m, logic [KEY_W-1:0] k, logic [WORD_W-1:0] w,
			bit d = 1'b0);
		pending_req_t p;
		p.req.mode       = m;
		p.req.owner_key  = k;
		p.req.write_word = w;
		p.drain          = d;
		pending_reqs.push_back(p);
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: rand_word = '0;
			1: rand_word = '1;
			default: rand_word = raw[WORD_W-1:0];
		endcase
	endfunction

	logic [KEY_W-1:0] key_pool [40];

	initial begin
		logic [KEY_W-1:0] k;
		logic [1:0]       m;
		int               pool_n;
		int               alloc_pct;
		int               sel;

		// directed: misses on an empty table
		push_req(MODE_GET,  '0, '1);
		push_req(MODE_SET,  '1, '1);
		push_req(MODE_FREE, '0, '0);
		// claim, repeat claim, extreme keys and words
		push_req(MODE_ALLOC, '0, '1);
		push_req(MODE_ALLOC, '0, '0);
		push_req(MODE_ALLOC, '1, '0);
		push_req(MODE_SET,   '1, '1);
		push_req(MODE_GET,   '1, '0);
		push_req(MODE_GET,   '0, '1);
		// free zeroes the word; the reclaimed slot reads back zero
		push_req(MODE_SET,   '0, 48'h5555_AAAA_5555);
		push_req(MODE_FREE,  '0, '0);
		push_req(MODE_ALLOC, '0, '1);
		push_req(MODE_GET,   '0, '0);
		// fill the rest, then one claim too many
		for (int i = 0; i < SLOTS - 2; i++)
			push_req(MODE_ALLOC, 32'hA500_0000 | i, '0);
		push_req(MODE_ALLOC, 32'h1234_5678, '1);
		push_req(MODE_GET, 32'hA500_000D, '0);

		// empty the table again, after a full drain
		push_req(MODE_FREE, '0, '0, 1'b1);
		push_req(MODE_FREE, '1, '0);
		for (int i = 0; i < SLOTS - 2; i++)
			push_req(MODE_FREE, 32'hA500_0000 | i, '0);

		// random phases, each with its own key pool and claim weight
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin pool_n = 4;  alloc_pct = 30; end
				1: begin pool_n = 12; alloc_pct = 25; end
				2: begin pool_n = 18; alloc_pct = 40; end
				3: begin pool_n = 24; alloc_pct = 35; end
				4: begin pool_n = 40; alloc_pct = 55; end
				default: begin pool_n = 17; alloc_pct = 30; end
			endcase
			for (int i = 0; i < pool_n; i++) begin
				key_pool[i] = $urandom;
				case ($urandom_range(0, 19))
					0: key_pool[i] = '0;
					1: key_pool[i] = '1;
					default: ;
				endcase
			end
			for (int n = 0; n < 165; n++) begin
				sel = $urandom_range(0, 99);
				if (sel < alloc_pct)
					m = MODE_ALLOC;
				else
					case ($urandom_range(0, 9))
						0, 1, 2, 3: m = MODE_GET;
						4, 5, 6:    m = MODE_SET;
						default:    m = MODE_FREE;
					endcase
				k   = key_pool[$urandom_range(0, pool_n - 1)];
				sel = $urandom_range(0, 99);
				if (sel >= 90) begin
					// unknown key
					k = $urandom;
					if (m == MODE_ALLOC)
						m = MODE_GET;
				end else if (sel >= 84) begin
					// key one bit off a pool key
					k = k ^ (32'd1 << $urandom_range(0, 31));
					if (m == MODE_ALLOC)
						m = MODE_FREE;
				end
				push_req(m, k, rand_word(), n == 0);
			end
			// release the pool so the next phase starts from an empty table
			for (int i = 0; i < pool_n; i++)
				push_req(MODE_FREE, key_pool[i], rand_word());
		end
	end

	// ---------------------------------------------------------------
	// end of run
	// ---------------------------------------------------------------
	initial begin
		@(posedge arst_n);
		while (pending_reqs.size() != 0 || start)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		// catch any stray strobe
		repeat (LATENCY + 4) @(posedge clk);
		$display("%0d requests transferred: %0d allocate, %0d get, %0d set, %0d free",
			mode_seen[0] + mode_seen[1] + mode_seen[2] + mode_seen[3],
			mode_seen[MODE_ALLOC], mode_seen[MODE_GET], mode_seen[MODE_SET],
			mode_seen[MODE_FREE]);
		$display("outcomes: %0d ok, %0d already present, %0d table full, %0d key not found",
			status_seen[ST_OK], status_seen[ST_PRESENT], status_seen[ST_FULL],
			status_seen[ST_MISSING]);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("FAIL");
		end
		$finish;
	end

	// timeout
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("FAIL");
		$finish;
	end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/kst_pkg.sv
rtl/core/kst_cell.sv
rtl/core/keyed_slot_table_top.sv
rtl/core/kst_checker.sv
tb/keyed_slot_table_top_tb.sv
